>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the code matcher RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, disabled while in reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed in code matcher");

// Next-cycle implication, sampled on aclk, disabled while in reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed in code matcher");

`endif

>>> rtl/core/crcm_pkg.sv
// ---------------------------------------------------------------------------
// crcm_pkg
// Types, constants and codes shared by the codespace range matcher.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package crcm_pkg;

    localparam int NUM_RANGES     = 16;
    localparam int MAX_CODE_BYTES = 4;

    localparam int IDX_W   = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
    localparam int COUNT_W = $clog2(NUM_RANGES + 1);

    localparam int FUNC_W   = 2;
    localparam int ENTRY_W  = 4;
    localparam int WORD_W   = 32;
    localparam int LEN_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int RCOUNT_W = 5;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 3;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 40;

    localparam logic [WORD_W-1:0] CODE_NONE = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_BYTE = 2'd1,
        FUNC_END  = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_FOUND    = 2'd0,
        STAT_NO_MATCH = 2'd1,
        STAT_NO_INPUT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // One codespace range as held in the table.
    typedef struct packed {
        logic [WORD_W-1:0] low;
        logic [WORD_W-1:0] high;
        logic [LEN_W-1:0]  len;
    } range_entry_t;

    // Verdict of the shared compare unit for one range.
    typedef struct packed {
        logic in_bounds;
        logic length_hit;
    } cmp_res_t;

endpackage

>>> rtl/core/codespace_range_char_code_matcher.sv
// ---------------------------------------------------------------------------
// codespace_range_char_code_matcher
// Builds character codes from a byte stream against a codespace range table.
// ---------------------------------------------------------------------------
// A load beat (tuser = 0) writes one range into the table and produces no
// result. A data-byte beat (tuser = 1) with a non-empty table extends the
// current code by one byte and then walks the table one range per cycle
// through a single shared compare unit, over each valid range (up to 16);
// the walk stops early at the first range that completes the code. With an
// empty table it drops the byte and any partial code. An end-of-input beat
// (tuser = 2) always produces a result. The table read port is registered,
// which is what sets the pace of one range per cycle. Input tready is high
// only while the sequencer is idle, but a finished result waits in its own
// output register, so new beats are taken while the downstream side stalls
// until a further result waits in the emit state. The range count register
// may only be written while the block is idle; counts above 16 act as 16.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module codespace_range_char_code_matcher (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,   // range_count

    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata fields from bit 0 up: entry_index[3:0], range_low_bytes[35:4],
    // range_high_bytes[67:36], range_length[70:68], data_byte[78:71], zero pad.
    input  logic [79:0] s_tdata,
    // tuser fields from bit 0 up: func[1:0].
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata fields from bit 0 up: char_code[31:0], bytes_used[34:32], zero pad.
    output logic [39:0] m_tdata,
    // tuser fields from bit 0 up: status[1:0].
    output logic [1:0]  m_tuser
);

    // Input field unpacking.
    logic [crcm_pkg::ENTRY_W-1:0] in_entry_index;
    logic [crcm_pkg::WORD_W-1:0]  in_low;
    logic [crcm_pkg::WORD_W-1:0]  in_high;
    logic [crcm_pkg::LEN_W-1:0]   in_length;
    logic [crcm_pkg::BYTE_W-1:0]  in_byte;
    crcm_pkg::func_t              in_func;

    assign in_entry_index = s_tdata[3:0];
    assign in_low         = s_tdata[35:4];
    assign in_high        = s_tdata[67:36];
    assign in_length      = s_tdata[70:68];
    assign in_byte        = s_tdata[78:71];
    assign in_func        = crcm_pkg::func_t'(s_tuser);

    // Sequencer and code state.
    crcm_pkg::state_t                   state_reg, state_next;
    logic [crcm_pkg::IDX_W-1:0]         idx_reg, idx_next;
    logic [crcm_pkg::NUM_RANGES-1:0]    cand_reg, cand_next;
    logic [crcm_pkg::WORD_W-1:0]        acc_reg, acc_next;
    logic [crcm_pkg::USED_W-1:0]        pos_reg, pos_next;
    logic [crcm_pkg::BYTE_W-1:0]        byte_reg, byte_next;
    logic [crcm_pkg::RCOUNT_W-1:0]      range_count_reg;

    // Result waiting for the output register.
    crcm_pkg::status_t                  pend_status_reg, pend_status_next;
    logic [crcm_pkg::WORD_W-1:0]        pend_code_reg, pend_code_next;
    logic [crcm_pkg::USED_W-1:0]        pend_used_reg, pend_used_next;

    // Output register.
    logic                               out_valid_reg, out_valid_next;
    crcm_pkg::status_t                  out_status_reg, out_status_next;
    logic [crcm_pkg::WORD_W-1:0]        out_code_reg, out_code_next;
    logic [crcm_pkg::USED_W-1:0]        out_used_reg, out_used_next;

    logic                               accept;
    logic                               out_free;
    logic [crcm_pkg::COUNT_W-1:0]       count_eff;
    logic                               last_range;
    logic [crcm_pkg::USED_W-1:0]        pos_plus1;

    logic                               mem_wr_en;
    crcm_pkg::range_entry_t             mem_wr_entry;
    crcm_pkg::range_entry_t             mem_rd_entry;
    crcm_pkg::cmp_res_t                 cmp_res;

    assign s_tready = (state_reg == crcm_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Counts beyond the table size act as a full table.
    assign count_eff = (int'(range_count_reg) > crcm_pkg::NUM_RANGES)
                     ? crcm_pkg::COUNT_W'(crcm_pkg::NUM_RANGES)
                     : crcm_pkg::COUNT_W'(range_count_reg);

    assign last_range = ((crcm_pkg::COUNT_W'(idx_reg) + crcm_pkg::COUNT_W'(1)) >= count_eff);
    assign pos_plus1  = pos_reg + crcm_pkg::USED_W'(1);

    // Loads go straight to the table; slots past the table size are dropped.
    assign mem_wr_en         = accept && (in_func == crcm_pkg::FUNC_LOAD)
                               && (int'(in_entry_index) < crcm_pkg::NUM_RANGES);
    assign mem_wr_entry.low  = in_low;
    assign mem_wr_entry.high = in_high;
    assign mem_wr_entry.len  = in_length;

    // The read address follows the next scan index, so the registered read
    // data lines up with idx_reg during the scan.
    crcm_range_mem u_mem (
        .aclk     (aclk),
        .wr_en    (mem_wr_en),
        .wr_addr  (crcm_pkg::IDX_W'(in_entry_index)),
        .wr_entry (mem_wr_entry),
        .rd_addr  (idx_next),
        .rd_entry (mem_rd_entry)
    );

    crcm_range_cmp u_cmp (
        .entry     (mem_rd_entry),
        .data_byte (byte_reg),
        .pos       (pos_reg[1:0]),
        .res       (cmp_res)
    );

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        cand_next        = cand_reg;
        acc_next         = acc_reg;
        pos_next         = pos_reg;
        byte_next        = byte_reg;
        pend_status_next = pend_status_reg;
        pend_code_next   = pend_code_reg;
        pend_used_next   = pend_used_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_code_next    = out_code_reg;
        out_used_next    = out_used_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            crcm_pkg::ST_IDLE: begin
                if (accept) begin
                    case (in_func)
                        crcm_pkg::FUNC_BYTE: begin
                            if (count_eff == '0) begin
                                // Empty table: drop the byte and any partial code.
                                pend_status_next = crcm_pkg::STAT_NO_INPUT;
                                pend_code_next   = crcm_pkg::CODE_NONE;
                                pend_used_next   = '0;
                                cand_next        = '1;
                                acc_next         = '0;
                                pos_next         = '0;
                                state_next       = crcm_pkg::ST_EMIT;
                            end else begin
                                byte_next  = in_byte;
                                acc_next   = {acc_reg[23:0], in_byte};
                                idx_next   = '0;
                                state_next = crcm_pkg::ST_SCAN;
                            end
                        end
                        crcm_pkg::FUNC_END: begin
                            if (pos_reg == '0) begin
                                pend_status_next = crcm_pkg::STAT_NO_INPUT;
                            end else begin
                                pend_status_next = crcm_pkg::STAT_NO_MATCH;
                            end
                            pend_code_next = crcm_pkg::CODE_NONE;
                            pend_used_next = pos_reg;
                            cand_next      = '1;
                            acc_next       = '0;
                            pos_next       = '0;
                            state_next     = crcm_pkg::ST_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            crcm_pkg::ST_SCAN: begin
                if (cand_reg[idx_reg] && cmp_res.in_bounds && cmp_res.length_hit) begin
                    // First surviving range of the right length ends the code.
                    pend_status_next = crcm_pkg::STAT_FOUND;
                    pend_code_next   = acc_reg;
                    pend_used_next   = pos_plus1;
                    cand_next        = '1;
                    acc_next         = '0;
                    pos_next         = '0;
                    state_next       = crcm_pkg::ST_EMIT;
                end else begin
                    if (cand_reg[idx_reg] && !cmp_res.in_bounds) begin
                        cand_next[idx_reg] = 1'b0;
                    end
                    if (last_range) begin
                        if (pos_plus1 >= crcm_pkg::USED_W'(crcm_pkg::MAX_CODE_BYTES)) begin
                            pend_status_next = crcm_pkg::STAT_NO_MATCH;
                            pend_code_next   = crcm_pkg::CODE_NONE;
                            pend_used_next   = crcm_pkg::USED_W'(crcm_pkg::MAX_CODE_BYTES);
                            cand_next        = '1;
                            acc_next         = '0;
                            pos_next         = '0;
                            state_next       = crcm_pkg::ST_EMIT;
                        end else begin
                            pos_next   = pos_plus1;
                            state_next = crcm_pkg::ST_IDLE;
                        end
                    end else begin
                        idx_next = idx_reg + crcm_pkg::IDX_W'(1);
                    end
                end
            end

            crcm_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_code_next   = pend_code_reg;
                    out_used_next   = pend_used_reg;
                    state_next      = crcm_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = crcm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= crcm_pkg::ST_IDLE;
            idx_reg         <= '0;
            cand_reg        <= '1;
            acc_reg         <= '0;
            pos_reg         <= '0;
            range_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cand_reg      <= cand_next;
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                range_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg        <= byte_next;
        pend_status_reg <= pend_status_next;
        pend_code_reg   <= pend_code_next;
        pend_used_reg   <= pend_used_next;
        out_status_reg  <= out_status_next;
        out_code_reg    <= out_code_next;
        out_used_reg    <= out_used_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_used_reg, out_code_reg};
    assign m_tuser  = out_status_reg;

    // The scan index never runs past the valid part of the table.
    `ASSERT_SAME(a_scan_in_table, state_reg == crcm_pkg::ST_SCAN,
                 crcm_pkg::COUNT_W'(idx_reg) < count_eff)

    // A byte taken with a non-empty table always starts a scan at range zero.
    `ASSERT_NEXT(a_byte_starts_scan,
                 accept && in_func == crcm_pkg::FUNC_BYTE && count_eff != '0,
                 state_reg == crcm_pkg::ST_SCAN && idx_reg == '0)

    // A pending "no input" result never claims consumed bytes.
    `ASSERT_SAME(a_no_input_zero_used,
                 state_reg == crcm_pkg::ST_EMIT && pend_status_reg == crcm_pkg::STAT_NO_INPUT,
                 pend_used_reg == '0)

endmodule

>>> rtl/core/crcm_range_mem.sv
// ---------------------------------------------------------------------------
// crcm_range_mem
// Codespace range table: one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module crcm_range_mem (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [crcm_pkg::IDX_W-1:0]  wr_addr,
    input  crcm_pkg::range_entry_t      wr_entry,
    input  logic [crcm_pkg::IDX_W-1:0]  rd_addr,
    output crcm_pkg::range_entry_t      rd_entry
);

    crcm_pkg::range_entry_t mem [crcm_pkg::NUM_RANGES];
    crcm_pkg::range_entry_t rd_entry_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        rd_entry_reg <= mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;

endmodule

>>> rtl/core/crcm_range_cmp.sv
// ---------------------------------------------------------------------------
// crcm_range_cmp
// Shared compare unit: checks one byte against one range at a byte position.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module crcm_range_cmp (
    input  crcm_pkg::range_entry_t       entry,
    input  logic [crcm_pkg::BYTE_W-1:0]  data_byte,
    input  logic [1:0]                   pos,
    output crcm_pkg::cmp_res_t           res
);

    logic [crcm_pkg::BYTE_W-1:0] lo_byte;
    logic [crcm_pkg::BYTE_W-1:0] hi_byte;
    logic [crcm_pkg::LEN_W-1:0]  len_want;

    // Byte position zero sits in the top byte of each bound word.
    always_comb begin
        case (pos)
            2'd0: begin
                lo_byte = entry.low[31:24];
                hi_byte = entry.high[31:24];
            end
            2'd1: begin
                lo_byte = entry.low[23:16];
                hi_byte = entry.high[23:16];
            end
            2'd2: begin
                lo_byte = entry.low[15:8];
                hi_byte = entry.high[15:8];
            end
            default: begin
                lo_byte = entry.low[7:0];
                hi_byte = entry.high[7:0];
            end
        endcase
    end

    assign len_want       = {1'b0, pos} + crcm_pkg::LEN_W'(1);
    assign res.in_bounds  = (data_byte >= lo_byte) && (data_byte <= hi_byte);
    assign res.length_hit = (entry.len == len_want);

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the codespace range character code matcher.
// ---------------------------------------------------------------------------
// A short directed script loads a small range table, walks the empty-table,
// end-of-input, odd-length, mid-code load and code-too-long cases, and then
// hands over to random traffic. The random part reloads every table slot and
// steps through several range counts, 0, 1, 16 and 31 among them. Most of its
// data beats spell codes that fit a chosen range, and the rest are stray
// bytes, end markers, reloads and the unused function code. A predictor in
// the bench tracks the table, the live candidate set and the partial code.
// Every result beat is compared with the oldest predicted result.
// ---------------------------------------------------------------------------
module tb;
    import crcm_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    localparam int IDLE_PCT     = 36;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 850;
    localparam int NUM_PHASES   = 8;
    localparam int SCRIPT_LEN   = 25;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        status_t             status;
        logic [WORD_W-1:0]   code;
        logic [USED_W-1:0]   used;
    } code_result_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TYPED,
        ROW_CONFIG
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [FUNC_W-1:0]     fn;
        logic [ENTRY_W-1:0]    slot;
        logic [WORD_W-1:0]     lo;
        logic [WORD_W-1:0]     hi;
        logic [LEN_W-1:0]      len;
        logic [BYTE_W-1:0]     data;
        code_result_t          want;
        logic [RCOUNT_W-1:0]   cfg_val;
    } script_row_t;

    localparam code_result_t NO_RESULT = '0;

    // DUT ports; the ones the bench drives are known from time zero.
    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [RCOUNT_W-1:0]   cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic [FUNC_W-1:0]     s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // Predictor state: range table, candidate set, partial code.
    logic [WORD_W-1:0]     bound_lo [NUM_RANGES];
    logic [WORD_W-1:0]     bound_hi [NUM_RANGES];
    logic [LEN_W-1:0]      code_len [NUM_RANGES];
    logic [NUM_RANGES-1:0] live_ranges;
    logic [WORD_W-1:0]     partial_code;
    int unsigned           bytes_in_code;
    int unsigned           range_cnt;

    code_result_t          expected_codes [$];
    script_row_t           script [SCRIPT_LEN];

    bit src_idle_on = 1'b1;
    bit snk_idle_on = 1'b1;
    bit hold_go     = 1'b0;
    bit rx_hold     = 1'b0;

    int mismatches    = 0;
    int beats_sent    = 0;
    int settings_used = 0;
    int found_cnt     = 0;
    int nomatch_cnt   = 0;
    int noinput_cnt   = 0;

    codespace_range_char_code_matcher u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------
    function automatic void restart_code();
        live_ranges   = '1;
        partial_code  = '0;
        bytes_in_code = 0;
    endfunction

    function automatic void finish_code(output code_result_t res, input status_t st,
                                        input logic [WORD_W-1:0] code,
                                        input int unsigned used);
        res.status = st;
        res.code   = code;
        res.used   = USED_W'(used);
        restart_code();
    endfunction

    // Applies one accepted input beat; returns 1 when it yields a result.
    function automatic bit match_step(input logic [FUNC_W-1:0] fn,
                                      input logic [S_TDATA_W-1:0] d,
                                      output code_result_t res);
        int unsigned       eff;
        int unsigned       i;
        int unsigned       sh;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] lo_b;
        logic [BYTE_W-1:0] hi_b;
        res = NO_RESULT;
        eff = (range_cnt > NUM_RANGES) ? NUM_RANGES : range_cnt;
        case (fn)
            FUNC_LOAD: begin
                bound_lo[d[3:0]] = d[35:4];
                bound_hi[d[3:0]] = d[67:36];
                code_len[d[3:0]] = d[70:68];
                return 1'b0;
            end
            FUNC_END: begin
                if (bytes_in_code == 0)
                    finish_code(res, STAT_NO_INPUT, CODE_NONE, 0);
                else
                    finish_code(res, STAT_NO_MATCH, CODE_NONE, bytes_in_code);
                return 1'b1;
            end
            FUNC_BYTE: begin
                // An empty table throws away the byte and any partial code.
                if (eff == 0) begin
                    finish_code(res, STAT_NO_INPUT, CODE_NONE, 0);
                    return 1'b1;
                end
                b = d[78:71];
                partial_code = {partial_code[23:0], b};
                sh = 24 - 8 * bytes_in_code;
                for (i = 0; i < eff; i++) begin
                    if (!live_ranges[i])
                        continue;
                    lo_b = bound_lo[i][sh +: 8];
                    hi_b = bound_hi[i][sh +: 8];
                    if (b < lo_b || b > hi_b) begin
                        live_ranges[i] = 1'b0;
                        continue;
                    end
                    // Lengths of 0 or above 4 can never satisfy this test.
                    if (32'(code_len[i]) == bytes_in_code + 1) begin
                        finish_code(res, STAT_FOUND, partial_code, bytes_in_code + 1);
                        return 1'b1;
                    end
                end
                bytes_in_code++;
                if (bytes_in_code >= MAX_CODE_BYTES) begin
                    finish_code(res, STAT_NO_MATCH, CODE_NONE, MAX_CODE_BYTES);
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    function automatic logic [S_TDATA_W-1:0] pack_beat(input logic [ENTRY_W-1:0] slot,
                                                       input logic [WORD_W-1:0] lo,
                                                       input logic [WORD_W-1:0] hi,
                                                       input logic [LEN_W-1:0] len,
                                                       input logic [BYTE_W-1:0] data);
        return {1'b0, data, len, hi, lo, slot};
    endfunction

    // Offers one beat, waits for the handshake, then records the prediction.
    // Valid is left high on return; the next call or a drain decides its level.
    task automatic send_beat(input logic [FUNC_W-1:0] fn, input logic [S_TDATA_W-1:0] d,
                             input bit use_typed, input code_result_t want);
        code_result_t res;
        bit           has;
        while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= fn;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        has = match_step(fn, d, res);
        if (use_typed) begin
            has = 1'b1;
            res = want;
        end
        if (has)
            expected_codes = {expected_codes, res};
        if (fn != FUNC_SPARE)
            beats_sent++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send_beat(FUNC_BYTE, pack_beat('0, '0, '0, '0, b), 1'b0, NO_RESULT);
    endtask

    // Mostly ordered per-byte bounds, now and then inverted or fully random.
    task automatic send_load(input logic [ENTRY_W-1:0] slot);
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] z;
        int                p;
        lo = $urandom;
        hi = $urandom;
        if ($urandom_range(5) != 0) begin
            for (p = 0; p < 4; p++) begin
                a = 8'($urandom_range(255));
                z = 8'($urandom_range(255));
                if (a > z && $urandom_range(7) != 0) begin
                    lo[8*p +: 8] = z;
                    hi[8*p +: 8] = a;
                end else begin
                    lo[8*p +: 8] = a;
                    hi[8*p +: 8] = z;
                end
            end
        end
        len = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(7))
                                       : LEN_W'($urandom_range(4, 1));
        send_beat(FUNC_LOAD, pack_beat(slot, lo, hi, len, '0), 1'b0, NO_RESULT);
    endtask

    // Spells a code that fits one live range; a lower slot may still claim it.
    task automatic send_code_seq();
        int unsigned       eff;
        int unsigned       slot;
        int unsigned       n;
        int unsigned       k;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] z;
        eff = (range_cnt > NUM_RANGES) ? NUM_RANGES : range_cnt;
        if (eff == 0) begin
            send_byte(8'($urandom));
            return;
        end
        slot = $urandom_range(eff - 1);
        n = (code_len[slot] >= 1 && code_len[slot] <= 4) ? 32'(code_len[slot])
                                                          : $urandom_range(4, 1);
        for (k = 0; k < n; k++) begin
            a = bound_lo[slot][24 - 8*k +: 8];
            z = bound_hi[slot][24 - 8*k +: 8];
            send_byte((a <= z) ? 8'($urandom_range(z, a)) : 8'($urandom));
        end
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            send_code_seq();
        else if (r < 78)
            send_byte(8'($urandom));
        else if (r < 82)
            send_byte($urandom_range(1) ? 8'hFF : 8'h00);
        else if (r < 88)
            send_beat(FUNC_END, '0, 1'b0, NO_RESULT);
        else if (r < 96)
            send_load(ENTRY_W'($urandom_range(NUM_RANGES - 1)));
        else
            send_beat(FUNC_SPARE, pack_beat(ENTRY_W'($urandom), $urandom, $urandom,
                      LEN_W'($urandom), BYTE_W'($urandom)), 1'b0, NO_RESULT);
    endtask

    // Stops offering beats until every predicted result has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_codes.size() != 0)
            @(posedge aclk);
    endtask

    // The count may only change while the matcher is idle, so a drain and a
    // settling pause for trailing no-result beats come first.
    task automatic set_range_count(input logic [RCOUNT_W-1:0] val);
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        range_cnt = val;
        settings_used++;
    endtask

    // -----------------------------------------------------------------------
    // Result side
    // -----------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input code_result_t want,
                                 input code_result_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("[%0t] %s: expected status %0d code %h used %0d, %s %0d code %h used %0d",
                     $realtime, what, want.status, want.code, want.used,
                     "got status", got.status, got.code, got.used);
    endtask

    always @(posedge aclk) begin : sink_ready
        m_tready <= !rx_hold && !(snk_idle_on && $urandom_range(99) < IDLE_PCT);
    end

    // Long receiver hold-off, counted here so the sender keeps offering beats.
    initial begin : sink_holdoff
        wait (hold_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk) begin : result_check
        code_result_t got;
        code_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {status_t'(m_tuser), m_tdata[31:0], m_tdata[34:32]};
            case (got.status)
                STAT_FOUND:    found_cnt++;
                STAT_NO_MATCH: nomatch_cnt++;
                default:       noinput_cnt++;
            endcase
            if (expected_codes.size() == 0) begin
                flag_mismatch("unexpected result beat", NO_RESULT, got);
            end else begin
                want = expected_codes.pop_front();
                if (m_tuser !== want.status || m_tdata[31:0] !== want.code ||
                    m_tdata[34:32] !== want.used)
                    flag_mismatch("result mismatch", want, got);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin : stimulus
        logic [RCOUNT_W-1:0] phase_counts [NUM_PHASES];
        int                  phase;
        int                  phase_end;
        int                  guard;
        int                  s;
        bit                  mid_drained;

        restart_code();
        range_cnt = 0;
        mid_drained = 1'b0;

        // Slots 0..4: one-byte 00-7F, two-byte 80-9F/40-FC, a zero-length
        // A0 range, a four-byte A0-AF range and an all-FF range of length 7.
        script = '{
            '{ROW_TYPED,   FUNC_BYTE,  4'd0,  32'h0, 32'h0, 3'd0, 8'h00,
              {STAT_NO_INPUT, CODE_NONE, 3'd0}, 5'd0},
            '{ROW_TYPED,   FUNC_END,   4'd0,  32'h0, 32'h0, 3'd0, 8'h00,
              {STAT_NO_INPUT, CODE_NONE, 3'd0}, 5'd0},
            '{ROW_PREDICT, FUNC_SPARE, 4'd0,  32'h0, 32'h0, 3'd0, 8'h5A, NO_RESULT, 5'd0},
            '{ROW_PREDICT, FUNC_LOAD,  4'd0,  32'h00000000, 32'h7FFFFFFF, 3'd1, 8'h00,
              NO_RESULT, 5'd0},
            '{ROW_PREDICT, FUNC_LOAD,  4'd1,  32'h80400000, 32'h9FFCFFFF, 3'd2, 8'h00,
              NO_RESULT, 5'd0},
            '{ROW_PREDICT, FUNC_LOAD,  4'd2,  32'hA0000000, 32'hA0FFFFFF, 3'd0, 8'h00,
              NO_RESULT, 5'd0},
            '{ROW_PREDICT, FUNC_LOAD,  4'd3,  32'hA0000000, 32'hAFFFFFFF, 3'd4, 8'h00,
              NO_RESULT, 5'd0},
            '{ROW_PREDICT, FUNC_LOAD,  4'd4,  32'hFFFFFFFF, 32'hFFFFFFFF, 3'd7, 8'h00,
              NO_RESULT, 5'd0},
            '{ROW_CONFIG,  FUNC_LOAD,  4'd0,  32'h0, 32'h0, 3'd0, 8'h00, NO_RESULT, 5'd5},
            '{ROW_TYPED,   FUNC_BYTE,  4'd0,  32'h0, 32'h0, 3'd0, 8'h00,
              {STAT_FOUND, 32'h00000000, 3'd1}, 5'd0},
            '{ROW_TYPED,   FUNC_BYTE,  4'd0,  32'h0, 32'h0, 3'd0, 8'h7F,
              {STAT_FOUND, 32'h0000007F, 3'd1}, 5'd0},
            '{ROW_PREDICT, FUNC_BYTE,  4'd0,  32'h0, 32'h0, 3'd0, 8'h81, NO_RESULT, 5'd0},
            // A load in the middle of a code must not disturb it.
            '{ROW_PREDICT, FUNC_LOAD,  4'd15, 32'h0, 32'h0, 3'd1, 8'h00, NO_RESULT, 5'd0},
            '{ROW_PREDICT, FUNC_BYTE,  4'd0,  32'h0, 32'h0, 3'd0, 8'hFC, NO_RESULT, 5'd0},
            '{ROW_PREDICT, FUNC_BYTE,  4'd0,  32'h0, 32'h0, 3'd0, 8'h81, NO_RESULT, 5'd0},
            '{ROW_TYPED,   FUNC_END,   4'd0,  32'h0, 32'h0, 3'd0, 8'h00,
              {STAT_NO_MATCH, CODE_NONE, 3'd1}, 5'd0},
            '{ROW_PREDICT, FUNC_BYTE,  4'd0,  32'h0, 32'h0, 3'd0, 8'hA0, NO_RESULT, 5'd0},
            '{ROW_PREDICT, FUNC_BYTE,  4'd0,  32'h0, 32'h0, 3'd0, 8'h00, NO_RESULT, 5'd0},
            '{ROW_PREDICT, FUNC_BYTE,  4'd0,  32'h0, 32'h0, 3'd0, 8'hFF, NO_RESULT, 5'd0},
            '{ROW_PREDICT, FUNC_BYTE,  4'd0,  32'h0, 32'h0, 3'd0, 8'h12, NO_RESULT, 5'd0},
            // Only the length-7 range survives, so the fourth byte is too many.
            '{ROW_PREDICT, FUNC_BYTE,  4'd0,  32'h0, 32'h0, 3'd0, 8'hFF, NO_RESULT, 5'd0},
            '{ROW_PREDICT, FUNC_BYTE,  4'd0,  32'h0, 32'h0, 3'd0, 8'hFF, NO_RESULT, 5'd0},
            '{ROW_PREDICT, FUNC_BYTE,  4'd0,  32'h0, 32'h0, 3'd0, 8'hFF, NO_RESULT, 5'd0},
            '{ROW_TYPED,   FUNC_BYTE,  4'd0,  32'h0, 32'h0, 3'd0, 8'hFF,
              {STAT_NO_MATCH, CODE_NONE, 3'd4}, 5'd0},
            '{ROW_TYPED,   FUNC_END,   4'd0,  32'h0, 32'h0, 3'd0, 8'h00,
              {STAT_NO_INPUT, CODE_NONE, 3'd0}, 5'd0}
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[r]) begin
            if (script[r].kind == ROW_CONFIG)
                set_range_count(script[r].cfg_val);
            else
                send_beat(script[r].fn, pack_beat(script[r].slot, script[r].lo, script[r].hi,
                          script[r].len, script[r].data), script[r].kind == ROW_TYPED,
                          script[r].want);
        end

        // Fill every slot so any range count reads written entries only.
        for (s = 0; s < NUM_RANGES; s++)
            send_load(ENTRY_W'(s));

        phase_counts = '{5'd16, 5'd31, 5'd1, 5'd17, 5'd0,
                         RCOUNT_W'($urandom_range(15, 2)), 5'd16, 5'd8};
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            set_range_count(phase_counts[phase]);
            src_idle_on = (phase != 1);
            snk_idle_on = (phase != 1);
            if (phase == 2)
                hold_go = 1'b1;
            phase_end = beats_sent + RANDOM_ITEMS / NUM_PHASES;
            while (beats_sent < phase_end) begin
                random_item();
                // Halfway through this phase the sender waits for every result.
                if (phase == 3 && !mid_drained &&
                    beats_sent >= phase_end - RANDOM_ITEMS / (2 * NUM_PHASES)) begin
                    drain();
                    mid_drained = 1'b1;
                end
            end
        end

        s_tvalid <= 1'b0;
        for (guard = 0; guard < 20000 && expected_codes.size() != 0; guard++)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        while (expected_codes.size() != 0)
            flag_mismatch("missing result", expected_codes.pop_front(), NO_RESULT);

        $display("Sent %0d input beats under %0d range-count settings %s.",
                 beats_sent, settings_used, "(0, 1, 16, 17, 31 included)");
        $display("Checked %0d codes found, %0d no-match and %0d empty or no-input results.",
                 found_cnt, nomatch_cnt, noinput_cnt);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches in total.", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #(4_000_000);
        $display("Timed out with %0d results still pending.", expected_codes.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/crcm_pkg.sv
rtl/core/crcm_range_mem.sv
rtl/core/crcm_range_cmp.sv
rtl/core/codespace_range_char_code_matcher.sv
bench/tb.sv
